FILE: src/tpc_pkg.sv
package tpc_pkg;

    localparam int COORD_W = 32;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vertex_t;

    // Register indexes of the plane coefficients.
    typedef enum logic [1:0] {
        REG_A = 2'd0,
        REG_B = 2'd1,
        REG_C = 2'd2,
        REG_D = 2'd3
    } reg_idx_t;

endpackage

FILE: src/tpc_if.sv
interface tpc_vtx_if import tpc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] norm_x;
    logic signed [COORD_W-1:0] norm_y;
    logic signed [COORD_W-1:0] norm_z;

    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  output ready);
endinterface

interface tpc_out_if import tpc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic signed [COORD_W-1:0] out_nx;
    logic signed [COORD_W-1:0] out_ny;
    logic signed [COORD_W-1:0] out_nz;
    logic [1:0]                corner;
    logic                      run_last;

    modport source (output valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
                    corner, run_last, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
                  corner, run_last, output ready);
endinterface

FILE: src/triangle_plane_clipper_core.sv
// Vertex items 1 and 2 of a triangle are stored and give no result. The closing
// vertex then starts nine plane products, done in turn on the shared multiplier,
// and a classify step. A straddling triangle adds two crossings, each with its
// normalizing shifts, a bit-serial divide of FRACTION_BITS+1 steps and three multiplies.
// Reset (rst_n, asynchronous, active low) restores the plane to z >= 0 and the slot count.
module triangle_plane_clipper_core import tpc_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tpc_vtx_if.sink     vin,
    tpc_out_if.source   vout
);

    localparam int DW = 63 - FRACTION_BITS;
    localparam int TW = FRACTION_BITS + 1;
    localparam logic [63:0] LIMIT = 64'(1) << (62 - FRACTION_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_PMUL, S_PACC, S_CLASS, S_XSET, S_XSHIFT, S_XDIV,
        S_XMUL, S_XADD, S_EMIT
    } state_t;

    typedef struct packed {
        vertex_t                   pos;
        vertex_t                   nrm;
        logic [1:0]                corner;
        logic                      run_last;
    } out_item_t;

    state_t state_reg;
    logic signed [31:0] coef_reg [4];
    vertex_t v0_reg, v1_reg, v2_reg, nrm_reg, pab_reg, pac_reg;
    logic [1:0]  slot_reg;
    logic [1:0]  vi_reg, ci_reg, j_reg;
    logic signed [63:0] acc_reg, f0_reg, f1_reg, f2_reg;
    logic [1:0]  cnt_reg, s_reg, b_reg, c_reg;
    logic        edge_reg;
    logic [63:0] num_reg, den_reg;
    logic [TW-1:0] t_reg;
    logic [2:0]  k_reg;
    logic        div_start_reg;
    out_item_t   out_reg;
    logic        ov_reg;

    logic signed [COORD_W:0]     mul_a, mul_b;
    logic signed [2*COORD_W+1:0] prod, prod_sh;
    logic        div_done;
    logic [TW-1:0] div_q;

    function automatic vertex_t pick(vertex_t a0, vertex_t a1, vertex_t a2,
                                     logic [1:0] i);
        case (i)
            2'd0:    return a0;
            2'd1:    return a1;
            default: return a2;
        endcase
    endfunction

    function automatic logic signed [31:0] coord(vertex_t v, logic [1:0] j);
        case (j)
            2'd0:    return v.x;
            2'd1:    return v.y;
            default: return v.z;
        endcase
    endfunction

    function automatic logic signed [63:0] fsel(logic signed [63:0] a0,
                                                logic signed [63:0] a1,
                                                logic signed [63:0] a2,
                                                logic [1:0] i);
        case (i)
            2'd0:    return a0;
            2'd1:    return a1;
            default: return a2;
        endcase
    endfunction

    function automatic logic [63:0] mag(logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [1:0] nxt(logic [1:0] i);
        case (i)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    assign pready = 1'b1;

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_A:   prdata = coef_reg[0];
            REG_B:   prdata = coef_reg[1];
            REG_C:   prdata = coef_reg[2];
            default: prdata = coef_reg[3];
        endcase
    end

    // Shared multiplier operands: plane products, then edge interpolation.
    vertex_t near_v, far_v, cur_v;
    logic signed [31:0] near_c, far_c, cur_c;

    always_comb
    begin
        near_v = pick(v0_reg, v1_reg, v2_reg, s_reg);
        far_v  = pick(v0_reg, v1_reg, v2_reg, edge_reg ? c_reg : b_reg);
        cur_v  = pick(v0_reg, v1_reg, v2_reg, vi_reg);
        near_c = coord(near_v, j_reg);
        far_c  = coord(far_v, j_reg);
        cur_c  = coord(cur_v, ci_reg);
        if (state_reg == S_XMUL)
        begin
            mul_a = {far_c[31], far_c} - {near_c[31], near_c};
            mul_b = {{(COORD_W + 1 - TW){1'b0}}, t_reg};
        end
        else
        begin
            mul_a = {coef_reg[ci_reg][31], coef_reg[ci_reg]};
            mul_b = {cur_c[31], cur_c};
        end
    end

    assign prod_sh = prod >>> FRACTION_BITS;

    tpc_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    tpc_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (num_reg[DW-1:0]),
        .den   (den_reg[DW-1:0]),
        .done  (div_done),
        .quot  (div_q)
    );

    // Classification of the closed triangle.
    logic [2:0] in_mask;
    logic [1:0] count, s_sel;

    always_comb
    begin
        in_mask = {~f2_reg[63], ~f1_reg[63], ~f0_reg[63]};
        count   = 2'(in_mask[0]) + 2'(in_mask[1]) + 2'(in_mask[2]);
        if (in_mask[0] == (count == 2'd1))
            s_sel = 2'd0;
        else if (in_mask[1] == (count == 2'd1))
            s_sel = 2'd1;
        else
            s_sel = 2'd2;
    end

    // Result selection for emit step k.
    vertex_t    emit_pos;
    logic [1:0] emit_corner;
    logic       emit_last;

    always_comb
    begin
        emit_corner = (k_reg < 3'd3) ? k_reg[1:0] : 2'(k_reg - 3'd3);
        if (cnt_reg == 2'd3)
        begin
            emit_pos  = pick(v0_reg, v1_reg, v2_reg, k_reg[1:0]);
            emit_last = (k_reg == 3'd2);
        end
        else if (cnt_reg == 2'd1)
        begin
            emit_last = (k_reg == 3'd2);
            case (k_reg)
                3'd0:    emit_pos = near_v;
                3'd1:    emit_pos = pab_reg;
                default: emit_pos = pac_reg;
            endcase
        end
        else
        begin
            emit_last = (k_reg == 3'd5);
            case (k_reg)
                3'd0:    emit_pos = pab_reg;
                3'd1:    emit_pos = pick(v0_reg, v1_reg, v2_reg, b_reg);
                3'd2:    emit_pos = pac_reg;
                3'd3:    emit_pos = pac_reg;
                3'd4:    emit_pos = pick(v0_reg, v1_reg, v2_reg, b_reg);
                default: emit_pos = pick(v0_reg, v1_reg, v2_reg, c_reg);
            endcase
        end
    end

    logic        in_acc, load_out;
    logic [63:0] den_sum;
    logic signed [31:0] p_new;

    assign in_acc   = vin.valid && vin.ready;
    assign load_out = (state_reg == S_EMIT) && (!ov_reg || vout.ready);
    assign den_sum  = mag(fsel(f0_reg, f1_reg, f2_reg, s_reg))
                    + mag(fsel(f0_reg, f1_reg, f2_reg, edge_reg ? c_reg : b_reg));
    assign p_new    = near_c + prod_sh[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            ov_reg        <= 1'b0;
            div_start_reg <= 1'b0;
            coef_reg[0]   <= '0;
            coef_reg[1]   <= '0;
            coef_reg[2]   <= 32'sd65536;
            coef_reg[3]   <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (psel && penable && pwrite)
                coef_reg[paddr[3:2]] <= pwdata;

            if (load_out)
            begin
                out_reg <= '{pos: emit_pos, nrm: nrm_reg, corner: emit_corner,
                             run_last: emit_last};
                ov_reg  <= 1'b1;
            end
            else if (ov_reg && vout.ready)
                ov_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (slot_reg)
                            2'd0:
                            begin
                                v0_reg   <= '{vin.pos_x, vin.pos_y, vin.pos_z};
                                slot_reg <= 2'd1;
                            end
                            2'd1:
                            begin
                                v1_reg   <= '{vin.pos_x, vin.pos_y, vin.pos_z};
                                slot_reg <= 2'd2;
                            end
                            default:
                            begin
                                v2_reg    <= '{vin.pos_x, vin.pos_y, vin.pos_z};
                                nrm_reg   <= '{vin.norm_x, vin.norm_y, vin.norm_z};
                                slot_reg  <= 2'd0;
                                vi_reg    <= 2'd0;
                                ci_reg    <= 2'd0;
                                acc_reg   <= 64'(coef_reg[3]);
                                state_reg <= S_PMUL;
                            end
                        endcase
                    end
                end
                S_PMUL:
                    state_reg <= S_PACC;
                S_PACC:
                begin
                    if (ci_reg == 2'd2)
                    begin
                        case (vi_reg)
                            2'd0:    f0_reg <= acc_reg + prod_sh[63:0];
                            2'd1:    f1_reg <= acc_reg + prod_sh[63:0];
                            default: f2_reg <= acc_reg + prod_sh[63:0];
                        endcase
                        acc_reg <= 64'(coef_reg[3]);
                        ci_reg  <= 2'd0;
                        vi_reg  <= vi_reg + 2'd1;
                        state_reg <= (vi_reg == 2'd2) ? S_CLASS : S_PMUL;
                    end
                    else
                    begin
                        acc_reg   <= acc_reg + prod_sh[63:0];
                        ci_reg    <= ci_reg + 2'd1;
                        state_reg <= S_PMUL;
                    end
                end
                S_CLASS:
                begin
                    cnt_reg  <= count;
                    s_reg    <= s_sel;
                    b_reg    <= nxt(s_sel);
                    c_reg    <= nxt(nxt(s_sel));
                    edge_reg <= 1'b0;
                    k_reg    <= 3'd0;
                    if (count == 2'd0)
                        state_reg <= S_IDLE;
                    else if (count == 2'd3)
                        state_reg <= S_EMIT;
                    else
                        state_reg <= S_XSET;
                end
                S_XSET:
                begin
                    num_reg   <= mag(fsel(f0_reg, f1_reg, f2_reg, s_reg));
                    den_reg   <= (den_sum == 64'd0) ? 64'd1 : den_sum;
                    state_reg <= S_XSHIFT;
                end
                S_XSHIFT:
                begin
                    if (den_reg > LIMIT)
                    begin
                        num_reg <= num_reg >> 1;
                        den_reg <= den_reg >> 1;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_XDIV;
                    end
                end
                S_XDIV:
                begin
                    if (div_done)
                    begin
                        t_reg     <= div_q;
                        j_reg     <= 2'd0;
                        state_reg <= S_XMUL;
                    end
                end
                S_XMUL:
                    state_reg <= S_XADD;
                S_XADD:
                begin
                    if (edge_reg)
                    begin
                        case (j_reg)
                            2'd0:    pac_reg.x <= p_new;
                            2'd1:    pac_reg.y <= p_new;
                            default: pac_reg.z <= p_new;
                        endcase
                    end
                    else
                    begin
                        case (j_reg)
                            2'd0:    pab_reg.x <= p_new;
                            2'd1:    pab_reg.y <= p_new;
                            default: pab_reg.z <= p_new;
                        endcase
                    end
                    j_reg <= j_reg + 2'd1;
                    if (j_reg != 2'd2)
                        state_reg <= S_XMUL;
                    else if (!edge_reg)
                    begin
                        edge_reg  <= 1'b1;
                        state_reg <= S_XSET;
                    end
                    else
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (load_out)
                    begin
                        k_reg <= k_reg + 3'd1;
                        if (emit_last)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign vin.ready     = (state_reg == S_IDLE);
    assign vout.valid    = ov_reg;
    assign vout.out_x    = out_reg.pos.x;
    assign vout.out_y    = out_reg.pos.y;
    assign vout.out_z    = out_reg.pos.z;
    assign vout.out_nx   = out_reg.nrm.x;
    assign vout.out_ny   = out_reg.nrm.y;
    assign vout.out_nz   = out_reg.nrm.z;
    assign vout.corner   = out_reg.corner;
    assign vout.run_last = out_reg.run_last;

endmodule

FILE: src/tpc_mul.sv
module tpc_mul import tpc_pkg::*; (
    input  logic                        clk,
    input  logic signed [COORD_W:0]     op_a,
    input  logic signed [COORD_W:0]     op_b,
    output logic signed [2*COORD_W+1:0] prod
);

    logic signed [2*COORD_W+1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

FILE: src/tpc_div.sv
module tpc_div import tpc_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [62-FRACTION_BITS:0] num,
    input  logic [62-FRACTION_BITS:0] den,
    output logic                     done,
    output logic [FRACTION_BITS:0]   quot
);

    localparam int DW = 63 - FRACTION_BITS;
    localparam int TW = FRACTION_BITS + 1;
    localparam int CW = $clog2(TW + 1);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [TW-1:0] quot_reg;
    logic          feed_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;

    assign trial = {rem_reg, feed_reg};

    // One quotient bit per cycle; the numerator is num shifted up by the
    // fraction width, so only the low bit of num is still to be fed in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= {1'b0, num[DW-1:1]};
                feed_reg <= num[0];
                den_reg  <= den;
                quot_reg <= '0;
                cnt_reg  <= CW'(TW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                feed_reg <= 1'b0;
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg  <= DW'(trial - {1'b0, den_reg});
                    quot_reg <= {quot_reg[TW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= trial[DW-1:0];
                    quot_reg <= {quot_reg[TW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: src/tpc_checker.sv
module tpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] corner,
    input logic       run_last
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_corner_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> corner != 2'd3)
        else $error("corner out of range");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_last |-> corner == 2'd2)
        else $error("run ends inside a triangle");

    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && corner == 2'd1 |=> !out_valid || corner == 2'd2)
        else $error("triangle corners out of order");

endmodule

bind triangle_plane_clipper_core tpc_checker u_tpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (vout.valid),
    .out_ready (vout.ready),
    .corner    (vout.corner),
    .run_last  (vout.run_last)
);
